/* rtl/assert_macros.svh */
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property sampled on the rising edge of aclk and ignored while reset is held.
`define ASSERT_SYNC(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// An implication whose consequent is checked in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bmhq_pkg.sv */
`default_nettype none

package bmhq_pkg;

    localparam int unsigned KEY_W     = 32;
    localparam int unsigned PAY_W     = 16;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned DEPTH_DEF = 64;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] entry_key;
        logic [PAY_W-1:0]        entry_payload;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic signed [KEY_W-1:0] popped_key;
        logic [PAY_W-1:0]        popped_payload;
        logic [CNT_W-1:0]        entry_count;
    } rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } entry_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

endpackage

`default_nettype wire

/* rtl/bmhq_ram.sv */
`default_nettype none

module bmhq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/bmhq_cmp.sv */
`default_nettype none

module bmhq_cmp
    import bmhq_pkg::*;
(
    input  wire logic signed [KEY_W-1:0] key_a,
    input  wire logic signed [KEY_W-1:0] key_b,
    output cmp_t                         res
);

    // Both operands are signed, so this is the two's complement order of the keys.
    assign res.lt = key_a < key_b;
    assign res.eq = key_a == key_b;

endmodule

`default_nettype wire

/* rtl/binary_min_heap_queue.sv */
// A refused insert or an empty remove goes straight from idle to the final state. An insert
// moves each parent on the path from its new slot to the root down one level, then sinks the
// entry from the root; a remove takes the root, then the last entry, and sinks that entry.
// Throughput: one operation in flight, s_ready rises with m_valid; a sift level runs through
// S_CHK, S_L, S_R (if a right child exists) and S_DEC on the dual-port RAM and shared comparator.
// Reset (aresetn, synchronous, active low) empties the heap and sets the capacity to 64.
`default_nettype none
`include "assert_macros.svh"

module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire req_t             s_req,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output rsp_t                  m_rsp,
    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data
);

    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned IW   = AW + 2;
    localparam int unsigned CMPW = (CW > CNT_W) ? CW : CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SH_RD,
        ST_SH_WR,
        ST_RM_LAST,
        ST_RM_CAP,
        ST_S_CHK,
        ST_S_L,
        ST_S_R,
        ST_S_DEC,
        ST_FIN
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           cnt_reg;
    logic [CNT_W-1:0]        cap_reg;
    logic [AW-1:0]           at_reg;
    logic [AW-1:0]           m_reg;
    entry_t                  cur_reg;
    entry_t                  ch_reg;
    status_t                 status_reg;
    logic signed [KEY_W-1:0] pop_key_reg;
    logic [PAY_W-1:0]        pop_pay_reg;
    logic                    m_valid_reg;
    rsp_t                    m_rsp_reg;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    entry_t                  ram_wdata;
    logic [AW-1:0]           ram_raddr;
    entry_t                  ram_rdata;
    logic signed [KEY_W-1:0] cmp_a;
    logic signed [KEY_W-1:0] cmp_b;
    cmp_t                    cmp_res;

    logic [CMPW-1:0]         cnt_cmp;
    logic [CMPW-1:0]         cap_eff;
    logic                    heap_full;
    logic [IW-1:0]           cnt_ext;
    logic [IW-1:0]           lft_idx;
    logic [IW-1:0]           rgt_idx;
    logic [AW-1:0]           par_idx;
    logic [AW-1:0]           gpar_idx;

    bmhq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    bmhq_cmp u_cmp (
        .key_a (cmp_a),
        .key_b (cmp_b),
        .res   (cmp_res)
    );

    assign cnt_cmp   = CMPW'(cnt_reg);
    assign cap_eff   = (CMPW'(cap_reg) < CMPW'(DEPTH)) ? CMPW'(cap_reg) : CMPW'(DEPTH);
    assign heap_full = cnt_cmp >= cap_eff;
    assign cnt_ext   = IW'(cnt_reg);
    assign lft_idx   = {1'b0, at_reg, 1'b0} + IW'(1);
    assign rgt_idx   = {1'b0, at_reg, 1'b0} + IW'(2);
    assign par_idx   = (at_reg - AW'(1)) >> 1;
    assign gpar_idx  = (par_idx - AW'(1)) >> 1;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = at_reg;
        ram_wdata = cur_reg;
        ram_raddr = '0;
        cmp_a     = ch_reg.key;
        cmp_b     = ram_rdata.key;
        case (state_reg)
            ST_SH_RD: begin
                ram_raddr = par_idx;
            end
            ST_SH_WR: begin
                // Move the parent down one level and fetch the next one up meanwhile.
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ram_raddr = gpar_idx;
            end
            ST_RM_LAST: begin
                ram_raddr = cnt_reg[AW-1:0];
            end
            ST_S_CHK: begin
                if (lft_idx >= cnt_ext) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = lft_idx[AW-1:0];
                end
            end
            ST_S_L: begin
                ram_raddr = rgt_idx[AW-1:0];
            end
            ST_S_DEC: begin
                cmp_a  = cur_reg.key;
                cmp_b  = ch_reg.key;
                ram_we = 1'b1;
                if (!(cmp_res.lt || cmp_res.eq)) begin
                    ram_wdata = ch_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            // In the final state the output register is reloaded instead.
            if (m_valid_reg && m_ready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        pop_key_reg <= '0;
                        pop_pay_reg <= '0;
                        if (s_req.req_type == REQ_INSERT) begin
                            if (heap_full) begin
                                status_reg <= STATUS_FULL;
                                state_reg  <= ST_FIN;
                            end else begin
                                status_reg      <= STATUS_DONE;
                                cnt_reg         <= cnt_reg + CW'(1);
                                cur_reg.key     <= s_req.entry_key;
                                cur_reg.payload <= s_req.entry_payload;
                                at_reg          <= cnt_reg[AW-1:0];
                                state_reg       <= (cnt_reg == '0) ? ST_S_CHK : ST_SH_RD;
                            end
                        end else begin
                            if (cnt_reg == '0) begin
                                status_reg <= STATUS_EMPTY;
                                state_reg  <= ST_FIN;
                            end else begin
                                status_reg <= STATUS_DONE;
                                cnt_reg    <= cnt_reg - CW'(1);
                                state_reg  <= ST_RM_LAST;
                            end
                        end
                    end
                end
                ST_SH_RD: begin
                    state_reg <= ST_SH_WR;
                end
                ST_SH_WR: begin
                    at_reg <= par_idx;
                    if (par_idx == '0) begin
                        state_reg <= ST_S_CHK;
                    end
                end
                ST_RM_LAST: begin
                    pop_key_reg <= ram_rdata.key;
                    pop_pay_reg <= ram_rdata.payload;
                    state_reg   <= ST_RM_CAP;
                end
                ST_RM_CAP: begin
                    cur_reg   <= ram_rdata;
                    at_reg    <= '0;
                    state_reg <= (cnt_reg == '0) ? ST_FIN : ST_S_CHK;
                end
                ST_S_CHK: begin
                    state_reg <= (lft_idx >= cnt_ext) ? ST_FIN : ST_S_L;
                end
                ST_S_L: begin
                    ch_reg    <= ram_rdata;
                    m_reg     <= lft_idx[AW-1:0];
                    state_reg <= (rgt_idx < cnt_ext) ? ST_S_R : ST_S_DEC;
                end
                ST_S_R: begin
                    // On equal child keys the right child is taken.
                    if (!cmp_res.lt) begin
                        ch_reg <= ram_rdata;
                        m_reg  <= rgt_idx[AW-1:0];
                    end
                    state_reg <= ST_S_DEC;
                end
                ST_S_DEC: begin
                    if (cmp_res.lt || cmp_res.eq) begin
                        state_reg <= ST_FIN;
                    end else begin
                        at_reg    <= m_reg;
                        state_reg <= ST_S_CHK;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg              <= 1'b1;
                        m_rsp_reg.status         <= status_reg;
                        m_rsp_reg.popped_key     <= pop_key_reg;
                        m_rsp_reg.popped_payload <= pop_pay_reg;
                        m_rsp_reg.entry_count    <= cnt_cmp[CNT_W-1:0];
                        state_reg                <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_SYNC(a_cnt_bound, cnt_cmp <= CMPW'(DEPTH), "fill count exceeds the store depth")
    `ASSERT_SYNC(a_wr_below_cnt, !ram_we || (IW'(ram_waddr) < cnt_ext), "store write above fill count")
    `ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "new word taken while busy")
    `ASSERT_SYNC(a_refused_no_pop, !(m_valid && m_rsp.status != STATUS_DONE) || (m_rsp.popped_key == '0 && m_rsp.popped_payload == '0), "refused word carries popped fields")

endmodule

`default_nettype wire
